### hdl/urmg_pkg.sv
// Shared types and constants for the ultrasonic ranger with motor guard.
`default_nettype none
package urmg_pkg;

   localparam int CM_BITS      = 11;
   localparam int COUNT_BITS   = 7;
   localparam int WIDTH_BITS   = 5;
   localparam int PINS_BITS    = 4;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [CM_BITS-1:0]    CM_MAX    = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // Division by 58 of an echo width: widths at or above 58 * 2048 saturate,
   // the rest are halved and divided by 29 through a reciprocal multiply.
   localparam int CM_DIVISOR   = 58;
   localparam int SAT_US       = CM_DIVISOR * (1 << CM_BITS);
   localparam int SMALL_BITS   = 17;
   localparam int HALF_BITS    = SMALL_BITS - 1;
   localparam int RECIP_SHIFT  = 21;
   localparam int RECIP_BITS   = 17;
   localparam int PROD_BITS    = HALF_BITS + RECIP_BITS;
   localparam logic [RECIP_BITS-1:0] RECIP_29 =
      RECIP_BITS'(((1 << RECIP_SHIFT) + (CM_DIVISOR / 2) - 1) / (CM_DIVISOR / 2));

   localparam logic [2:0] REQ_TICK  = 3'd0;
   localparam logic [2:0] REQ_ECHO  = 3'd1;
   localparam logic [2:0] REQ_READ  = 3'd2;
   localparam logic [2:0] REQ_MOTOR = 3'd3;
   localparam logic [2:0] REQ_OPEN  = 3'd4;

   localparam logic [PINS_BITS-1:0] PINS_STOP     = 4'd0;
   localparam logic [PINS_BITS-1:0] PINS_FORWARD  = 4'd10;
   localparam logic [PINS_BITS-1:0] PINS_BACKWARD = 4'd5;
   localparam logic [PINS_BITS-1:0] PINS_LEFT     = 4'd6;
   localparam logic [PINS_BITS-1:0] PINS_RIGHT    = 4'd9;

   localparam logic [1:0] PHASE_CODE_NONE  = 2'd0;
   localparam logic [1:0] PHASE_CODE_RISE  = 2'd1;
   localparam logic [1:0] PHASE_CODE_FALL  = 2'd2;
   localparam logic [1:0] PHASE_CODE_READY = 2'd3;

   localparam logic [1:0] REG_STOP_DISTANCE = 2'd0;
   localparam logic [1:0] REG_ERROR_LIMIT   = 2'd1;
   localparam logic [1:0] REG_OPEN_TRIGGER  = 2'd2;
   localparam logic [1:0] REG_READ_TRIGGER  = 2'd3;

   typedef enum logic [2:0] {
      PH_RISE  = 3'b001,
      PH_FALL  = 3'b010,
      PH_READY = 3'b100
   } phase_type;

   typedef struct packed {
      logic [CM_BITS-1:0]    stop_distance_cm;
      logic [COUNT_BITS-1:0] error_limit;
      logic [WIDTH_BITS-1:0] open_trigger_us;
      logic [WIDTH_BITS-1:0] read_trigger_us;
   } csr_type;

   typedef struct packed {
      logic [2:0] req_type;
      logic       echo_level;
      logic       cmd_forward;
      logic       cmd_backward;
      logic       cmd_left;
      logic       cmd_right;
   } item_type;

   typedef struct packed {
      logic [1:0]            phase_now;
      logic                  measure_done;
      logic [CM_BITS-1:0]    newest_distance_cm;
      logic [CM_BITS-1:0]    older_distance_cm;
      logic [WIDTH_BITS-1:0] trigger_width_us;
      logic                  trigger_fire;
      logic [PINS_BITS-1:0]  motor_pins;
   } result_type;

endpackage
`default_nettype wire

### hdl/urmg_csr.sv
// Configuration register file with an APB-style access port.
`default_nettype none
module urmg_csr (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    csr_psel,
   input  wire                                    csr_penable,
   input  wire                                    csr_pwrite,
   input  wire  [urmg_pkg::CSR_ADDR_BITS-1:0]     csr_paddr,
   input  wire  [urmg_pkg::CSR_DATA_BITS-1:0]     csr_pwdata,
   output logic [urmg_pkg::CSR_DATA_BITS-1:0]     csr_prdata,
   output logic                                   csr_pready,
   output urmg_pkg::csr_type                      csr
);
   import urmg_pkg::*;

   csr_type    csr_ff;
   csr_type    csr_in;
   logic       write_en;
   logic [1:0] index;

   assign index      = csr_paddr[3:2];
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr        = csr_ff;

   always_comb begin
      csr_in = csr_ff;
      if (write_en) begin
         case (index)
            REG_STOP_DISTANCE: csr_in.stop_distance_cm = csr_pwdata[CM_BITS-1:0];
            REG_ERROR_LIMIT:   csr_in.error_limit      = csr_pwdata[COUNT_BITS-1:0];
            REG_OPEN_TRIGGER:  csr_in.open_trigger_us  = csr_pwdata[WIDTH_BITS-1:0];
            REG_READ_TRIGGER:  csr_in.read_trigger_us  = csr_pwdata[WIDTH_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_STOP_DISTANCE: csr_prdata = CSR_DATA_BITS'(csr_ff.stop_distance_cm);
         REG_ERROR_LIMIT:   csr_prdata = CSR_DATA_BITS'(csr_ff.error_limit);
         REG_OPEN_TRIGGER:  csr_prdata = CSR_DATA_BITS'(csr_ff.open_trigger_us);
         REG_READ_TRIGGER:  csr_prdata = CSR_DATA_BITS'(csr_ff.read_trigger_us);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.stop_distance_cm <= CM_BITS'(20);
         csr_ff.error_limit      <= COUNT_BITS'(100);
         csr_ff.open_trigger_us  <= WIDTH_BITS'(10);
         csr_ff.read_trigger_us  <= WIDTH_BITS'(20);
      end else begin
         csr_ff <= csr_in;
      end
   end

endmodule
`default_nettype wire

### hdl/urmg_div58.sv
// Echo width to centimeters: division by 58 with saturation at the field maximum.
`default_nettype none
module urmg_div58 #(
   parameter int TIMER_BITS = 16
) (
   input  wire  [TIMER_BITS-1:0]        elapsed_us,
   output logic [urmg_pkg::CM_BITS-1:0] distance_cm
);
   import urmg_pkg::*;

   logic [31:0]           wide;
   logic                  saturate;
   logic [SMALL_BITS-1:0] small_us;
   logic [HALF_BITS-1:0]  half_us;
   logic [PROD_BITS-1:0]  product;

   assign wide     = 32'(elapsed_us);
   assign saturate = wide >= 32'(SAT_US);
   assign small_us = wide[SMALL_BITS-1:0];
   assign half_us  = small_us[SMALL_BITS-1:1];
   assign product  = PROD_BITS'(half_us) * PROD_BITS'(RECIP_29);

   assign distance_cm = saturate ? CM_MAX : product[RECIP_SHIFT+CM_BITS-1:RECIP_SHIFT];

endmodule
`default_nettype wire

### hdl/urmg_core.sv
// Ranging sequencer state, echo timer, distance history and motor pin guard.
`default_nettype none
module urmg_core #(
   parameter int TIMER_BITS = 16
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  step,
   input  urmg_pkg::item_type   item,
   input  urmg_pkg::csr_type    csr,
   output urmg_pkg::result_type result
);
   import urmg_pkg::*;

   localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

   phase_type             phase_ff, phase_in;
   logic [TIMER_BITS-1:0] elapsed_ff, elapsed_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [CM_BITS-1:0]    latest_ff, latest_in;
   logic [CM_BITS-1:0]    previous_ff, previous_in;
   logic [PINS_BITS-1:0]  pins_ff, pins_in;
   logic [CM_BITS-1:0]    distance_cm;
   logic                  fire;
   logic [WIDTH_BITS-1:0] width;
   logic                  done;
   logic                  read_ready;
   logic [1:0]            phase_code;

   urmg_div58 #(.TIMER_BITS(TIMER_BITS)) u_div58 (
      .elapsed_us  (elapsed_ff),
      .distance_cm (distance_cm)
   );

   assign read_ready = (phase_ff == PH_READY) || (count_ff > csr.error_limit);

   always_comb begin
      phase_in    = phase_ff;
      elapsed_in  = elapsed_ff;
      count_in    = count_ff;
      latest_in   = latest_ff;
      previous_in = previous_ff;
      pins_in     = pins_ff;
      fire        = 1'b0;
      width       = '0;
      done        = 1'b0;
      case (item.req_type)
         REQ_TICK: begin
            if (phase_ff == PH_FALL && elapsed_ff != TIMER_MAX) begin
               elapsed_in = elapsed_ff + 1'b1;
            end
         end
         REQ_ECHO: begin
            if (phase_ff == PH_RISE && item.echo_level) begin
               elapsed_in = '0;
               phase_in   = PH_FALL;
            end else if (phase_ff == PH_FALL && !item.echo_level) begin
               previous_in = latest_ff;
               latest_in   = distance_cm;
               if (distance_cm < csr.stop_distance_cm) begin
                  pins_in = PINS_STOP;
               end
               phase_in = PH_READY;
               done     = 1'b1;
            end
         end
         REQ_READ: begin
            if (read_ready) begin
               elapsed_in = '0;
               phase_in   = PH_RISE;
               fire       = 1'b1;
               width      = csr.read_trigger_us;
               count_in   = '0;
            end else if (count_ff != COUNT_MAX) begin
               count_in = count_ff + 1'b1;
            end
         end
         REQ_MOTOR: begin
            if (item.cmd_forward) begin
               pins_in = PINS_FORWARD;
            end else if (item.cmd_backward) begin
               pins_in = PINS_BACKWARD;
            end else if (item.cmd_left) begin
               pins_in = PINS_LEFT;
            end else if (item.cmd_right) begin
               pins_in = PINS_RIGHT;
            end else begin
               pins_in = PINS_STOP;
            end
         end
         REQ_OPEN: begin
            if (phase_ff == PH_READY) begin
               elapsed_in = '0;
               phase_in   = PH_RISE;
               fire       = 1'b1;
               width      = csr.open_trigger_us;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      case (phase_in)
         PH_RISE:  phase_code = PHASE_CODE_RISE;
         PH_FALL:  phase_code = PHASE_CODE_FALL;
         PH_READY: phase_code = PHASE_CODE_READY;
         default:  phase_code = PHASE_CODE_NONE;
      endcase
   end

   assign result.motor_pins         = pins_in;
   assign result.trigger_fire       = fire;
   assign result.trigger_width_us   = width;
   assign result.older_distance_cm  = previous_in;
   assign result.newest_distance_cm = latest_in;
   assign result.measure_done       = done;
   assign result.phase_now          = phase_code;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_READY;
         elapsed_ff  <= '0;
         count_ff    <= '0;
         latest_ff   <= '0;
         previous_ff <= '0;
         pins_ff     <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         elapsed_ff  <= elapsed_in;
         count_ff    <= count_in;
         latest_ff   <= latest_in;
         previous_ff <= previous_in;
         pins_ff     <= pins_in;
      end
   end

   // A finished measurement always leaves the sequencer ready.
   assert property (@(posedge clock) disable iff (reset)
      step && done |=> phase_ff == PH_READY)
      else $error("measurement finished without returning to ready");

   // A trigger starts a fresh wait for the echo rise with a cleared timer.
   assert property (@(posedge clock) disable iff (reset)
      step && fire |=> phase_ff == PH_RISE && elapsed_ff == '0)
      else $error("trigger did not restart the measurement");

   // The echo timer only advances while the echo is high.
   assert property (@(posedge clock) disable iff (reset)
      elapsed_ff != '0 && elapsed_ff != $past(elapsed_ff) |->
         $past(phase_ff) == PH_FALL)
      else $error("echo timer moved outside the echo pulse");

endmodule
`default_nettype wire

### hdl/ultrasonic_ranger_motor_guard.sv
// Top level of the ultrasonic ranger with motor guard: stream ports, item and result registers.
//
// Every item produces exactly one result. An item is taken into an input register,
// processed by single-pass logic whose longest path is the reciprocal multiply that
// turns the echo width into centimeters, and its result is held in an output register
// until taken. The block accepts one item per clock cycle while results are taken, and
// a result is offered from the output register once its item has left the input register.
// Configuration registers are read and written through the APB-style port with no wait
// states and take effect for items that leave the input register after the write.
`default_nettype none
module ultrasonic_ranger_motor_guard #(
   parameter int TIMER_BITS = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // Bits from 0: echo_level, cmd_forward, cmd_backward, cmd_left, cmd_right, zero fill.
   input  wire  [7:0]  req_tdata,
   // Bits from 0: req_type.
   input  wire  [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // Bits from 0: motor_pins[3:0], trigger_fire[4], trigger_width_us[9:5],
   // older_distance_cm[20:10], newest_distance_cm[31:21], measure_done[32],
   // phase_now[34:33], zero fill.
   output logic [39:0] rsp_tdata,
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [urmg_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire  [urmg_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [urmg_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic        csr_pready
);
   import urmg_pkg::*;

   csr_type    csr;
   item_type   item_ff, item_in;
   logic       item_valid_ff;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       advance;
   logic       accept;

   assign advance    = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   assign item_in.req_type     = req_tuser;
   assign item_in.echo_level   = req_tdata[0];
   assign item_in.cmd_forward  = req_tdata[1];
   assign item_in.cmd_backward = req_tdata[2];
   assign item_in.cmd_left     = req_tdata[3];
   assign item_in.cmd_right    = req_tdata[4];

   urmg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .csr         (csr)
   );

   urmg_core #(.TIMER_BITS(TIMER_BITS)) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item_ff),
      .csr    (csr),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (accept) begin
         item_valid_ff <= 1'b1;
      end else if (advance) begin
         item_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_ff.phase_now, rsp_ff.measure_done,
                        rsp_ff.newest_distance_cm, rsp_ff.older_distance_cm,
                        rsp_ff.trigger_width_us, rsp_ff.trigger_fire, rsp_ff.motor_pins};

endmodule
`default_nettype wire

### test/ultrasonic_ranger_motor_guard_tb.sv
// Self-checking testbench for the ultrasonic ranger with motor guard: stream items, APB registers.
`timescale 1ns / 1ps
module ultrasonic_ranger_motor_guard_tb;
   import urmg_pkg::*;

   localparam int TIMER_BITS = 16;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int RANDOM_PHASES = 4;
   localparam int RANDOM_ITEMS = 130;

   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_LIGHT, STALL_HEAVY} stall_mode_type;

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = '0;
   logic [2:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   csr_type ranger_csr = '{stop_distance_cm: 20, error_limit: 100,
                           open_trigger_us: 10, read_trigger_us: 20};
   logic [1:0] ranger_phase = PHASE_CODE_READY;
   logic [TIMER_BITS-1:0] echo_us = '0;
   logic [COUNT_BITS-1:0] busy_reads = '0;
   logic [CM_BITS-1:0] newest_cm = '0;
   logic [CM_BITS-1:0] older_cm = '0;
   logic [PINS_BITS-1:0] pins = PINS_STOP;

   result_type awaited_status[$];
   int errors = 0;
   int burst_left = 0;
   int sent_items = 0;
   bit hold_off_requested = 1'b0;

   ultrasonic_ranger_motor_guard #(.TIMER_BITS(TIMER_BITS)) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic result_type advance_ranger(input logic [2:0] kind, input logic level,
                                                 input logic [3:0] cmds);
      result_type status;
      int unsigned cm;
      status = '0;
      case (kind)
         REQ_TICK: begin
            if (ranger_phase == PHASE_CODE_FALL && echo_us != '1) echo_us = echo_us + 1'b1;
         end
         REQ_ECHO: begin
            if (ranger_phase == PHASE_CODE_RISE) begin
               if (level) begin
                  echo_us = '0;
                  ranger_phase = PHASE_CODE_FALL;
               end
            end else if (ranger_phase == PHASE_CODE_FALL && !level) begin
               cm = echo_us / CM_DIVISOR;
               if (cm > CM_MAX) cm = CM_MAX;
               older_cm = newest_cm;
               newest_cm = CM_BITS'(cm);
               if (cm < ranger_csr.stop_distance_cm) pins = PINS_STOP;
               ranger_phase = PHASE_CODE_READY;
               status.measure_done = 1'b1;
            end
         end
         REQ_READ: begin
            if (busy_reads > ranger_csr.error_limit) ranger_phase = PHASE_CODE_READY;
            if (ranger_phase == PHASE_CODE_READY) begin
               echo_us = '0;
               ranger_phase = PHASE_CODE_RISE;
               status.trigger_fire = 1'b1;
               status.trigger_width_us = ranger_csr.read_trigger_us;
               busy_reads = '0;
            end else if (busy_reads != COUNT_MAX) begin
               busy_reads = busy_reads + 1'b1;
            end
         end
         REQ_MOTOR: begin
            if (cmds[0]) pins = PINS_FORWARD;
            else if (cmds[1]) pins = PINS_BACKWARD;
            else if (cmds[2]) pins = PINS_LEFT;
            else if (cmds[3]) pins = PINS_RIGHT;
            else pins = PINS_STOP;
         end
         REQ_OPEN: begin
            if (ranger_phase == PHASE_CODE_READY) begin
               echo_us = '0;
               ranger_phase = PHASE_CODE_RISE;
               status.trigger_fire = 1'b1;
               status.trigger_width_us = ranger_csr.open_trigger_us;
            end
         end
         default: ;
      endcase
      status.motor_pins = pins;
      status.older_distance_cm = older_cm;
      status.newest_distance_cm = newest_cm;
      status.phase_now = ranger_phase;
      return status;
   endfunction

   task automatic report_mismatch(input string field, input longint want, input longint got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      errors++;
   endtask

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = result_type'(rsp_tdata[$bits(result_type)-1:0]);
         if (awaited_status.size() == 0) begin
            $display("%0t: unexpected item, expected none, actual %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = awaited_status.pop_front();
            if (got.motor_pins !== want.motor_pins)
               report_mismatch("motor_pins", want.motor_pins, got.motor_pins);
            if (got.trigger_fire !== want.trigger_fire)
               report_mismatch("trigger_fire", want.trigger_fire, got.trigger_fire);
            if (got.trigger_width_us !== want.trigger_width_us)
               report_mismatch("trigger_width_us", want.trigger_width_us, got.trigger_width_us);
            if (got.older_distance_cm !== want.older_distance_cm)
               report_mismatch("older_distance_cm", want.older_distance_cm,
                               got.older_distance_cm);
            if (got.newest_distance_cm !== want.newest_distance_cm)
               report_mismatch("newest_distance_cm", want.newest_distance_cm,
                               got.newest_distance_cm);
            if (got.measure_done !== want.measure_done)
               report_mismatch("measure_done", want.measure_done, got.measure_done);
            if (got.phase_now !== want.phase_now)
               report_mismatch("phase_now", want.phase_now, got.phase_now);
            if (rsp_tdata[39:$bits(result_type)] !== '0)
               report_mismatch("zero fill", 0, rsp_tdata[39:$bits(result_type)]);
         end
      end
   end

   initial begin : receiver
      stall_mode_type stall_mode;
      int mode_left;
      int step;
      stall_mode = STALL_NONE;
      mode_left = 0;
      step = 0;
      forever begin
         @(posedge clock);
         if (hold_off_requested) begin
            hold_off_requested = 1'b0;
            rsp_tready <= 1'b0;
            for (int held = 0; held < HOLD_OFF_CYCLES; held++) @(posedge clock);
         end
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(8, 60);
         end
         mode_left--;
         step++;
         case (stall_mode)
            STALL_NONE: rsp_tready <= 1'b1;
            STALL_RANDOM: rsp_tready <= 1'($urandom_range(0, 1));
            STALL_LIGHT: rsp_tready <= (step % 4) != 0;
            default: rsp_tready <= (step % 4) == 0;
         endcase
      end
   end

   task automatic send_item(input logic [2:0] kind, input logic level, input logic [3:0] cmds);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {3'b000, cmds, level};
      do @(posedge clock); while (!req_tready);
      awaited_status.push_back(advance_ranger(kind, level, cmds));
      sent_items++;
      burst_left--;
   endtask

   task automatic send_noise();
      send_item(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
   endtask

   task automatic send_ticks(input int count);
      for (int i = 0; i < count; i++)
         send_item(REQ_TICK, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (awaited_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [1:0] index,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= CSR_ADDR_BITS'({index, 2'b00});
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic check_register(input logic [1:0] index);
      logic [31:0] want;
      logic [31:0] got;
      case (index)
         REG_STOP_DISTANCE: want = 32'(ranger_csr.stop_distance_cm);
         REG_ERROR_LIMIT: want = 32'(ranger_csr.error_limit);
         REG_OPEN_TRIGGER: want = 32'(ranger_csr.open_trigger_us);
         default: want = 32'(ranger_csr.read_trigger_us);
      endcase
      csr_access(1'b0, index, '0, got);
      if (got !== want) begin
         $display("%0t: register %0d read, expected %0d, actual %0d", $time, index, want, got);
         errors++;
      end
   endtask

   task automatic set_register(input logic [1:0] index, input int unsigned value);
      logic [31:0] unused;
      csr_access(1'b1, index, 32'(value), unused);
      case (index)
         REG_STOP_DISTANCE: ranger_csr.stop_distance_cm = CM_BITS'(value);
         REG_ERROR_LIMIT: ranger_csr.error_limit = COUNT_BITS'(value);
         REG_OPEN_TRIGGER: ranger_csr.open_trigger_us = WIDTH_BITS'(value);
         default: ranger_csr.read_trigger_us = WIDTH_BITS'(value);
      endcase
      check_register(index);
   endtask

   task automatic configure(input int unsigned stop_cm, input int unsigned limit,
                            input int unsigned open_us, input int unsigned read_us);
      wait_idle();
      set_register(REG_STOP_DISTANCE, stop_cm);
      set_register(REG_ERROR_LIMIT, limit);
      set_register(REG_OPEN_TRIGGER, open_us);
      set_register(REG_READ_TRIGGER, read_us);
   endtask

   task automatic test_status_requests();
      for (int i = 0; i < 4; i++) check_register(2'(i));
      for (int i = 0; i < 3; i++) send_item(3'(REQ_OPEN + 1 + i), 1'b1, 4'b1111);
      send_item(REQ_TICK, 1'b1, 4'b1111);
      send_item(REQ_ECHO, 1'b1, 4'b0000);
      send_item(REQ_ECHO, 1'b0, 4'b0000);
      send_item(REQ_MOTOR, 1'b1, 4'b1111);
      send_item(REQ_MOTOR, 1'b0, 4'b1110);
      send_item(REQ_MOTOR, 1'b1, 4'b1100);
      send_item(REQ_MOTOR, 1'b0, 4'b1000);
      send_item(REQ_MOTOR, 1'b0, 4'b0000);
   endtask

   task automatic test_measurement_cycle();
      send_item(REQ_MOTOR, 1'b0, 4'b0001);
      send_item(REQ_OPEN, 1'b0, 4'b0000);
      send_item(REQ_OPEN, 1'b1, 4'b1111);
      send_item(REQ_READ, 1'b0, 4'b0000);
      send_item(REQ_TICK, 1'b0, 4'b0000);
      send_item(REQ_ECHO, 1'b0, 4'b0000);
      send_item(REQ_ECHO, 1'b1, 4'b0000);
      send_item(REQ_ECHO, 1'b1, 4'b0000);
      send_ticks(3);
      send_item(REQ_ECHO, 1'b0, 4'b0000);
      send_item(REQ_READ, 1'b1, 4'b1111);
   endtask

   task automatic test_register_extremes();
      configure(0, 0, 0, 0);
      send_item(REQ_MOTOR, 1'b0, 4'b0001);
      send_item(REQ_ECHO, 1'b1, 4'b0000);
      send_item(REQ_ECHO, 1'b0, 4'b0000);
      send_item(REQ_OPEN, 1'b0, 4'b0000);
      send_item(REQ_READ, 1'b0, 4'b0000);
      send_item(REQ_READ, 1'b0, 4'b0000);
      send_item(REQ_ECHO, 1'b1, 4'b0000);
      send_item(REQ_ECHO, 1'b0, 4'b0000);
      configure(1129, 126, 31, 31);
      send_item(REQ_OPEN, 1'b0, 4'b0000);
      send_item(REQ_ECHO, 1'b1, 4'b0000);
      send_item(REQ_ECHO, 1'b0, 4'b0000);
      send_item(REQ_READ, 1'b0, 4'b0000);
   endtask

   task automatic test_busy_read_limit();
      configure(20, 3, 10, 20);
      send_item(REQ_OPEN, 1'b0, 4'b0000);
      for (int i = 0; i < 6; i++) send_item(REQ_READ, 1'($urandom_range(0, 1)), 4'b0000);
      wait_idle();
      set_register(REG_ERROR_LIMIT, 127);
      for (int i = 0; i < 130; i++) send_item(REQ_READ, 1'b0, 4'($urandom_range(0, 15)));
      send_item(REQ_ECHO, 1'b1, 4'b0000);
      send_item(REQ_ECHO, 1'b0, 4'b0000);
      send_item(REQ_READ, 1'b0, 4'b0000);
      send_item(REQ_READ, 1'b0, 4'b0000);
   endtask

   task automatic test_distance_guard();
      configure(1129, 100, 10, 20);
      send_item(REQ_MOTOR, 1'b0, 4'b0010);
      send_item(REQ_OPEN, 1'b0, 4'b0000);
      send_item(REQ_ECHO, 1'b1, 4'b0000);
      send_ticks(2 * CM_DIVISOR + 1);
      send_item(REQ_ECHO, 1'b0, 4'b0000);
   endtask

   task automatic test_backpressure();
      wait_idle();
      hold_off_requested = 1'b1;
      for (int i = 0; i < 24; i++) begin
         if (i % 3 == 0) send_item(REQ_MOTOR, 1'b0, 4'($urandom_range(0, 15)));
         else send_noise();
      end
   endtask

   task automatic run_measurement_sequence();
      int ticks;
      int pick;
      send_item(($urandom_range(0, 1) == 0) ? REQ_OPEN : REQ_READ, 1'($urandom_range(0, 1)),
                4'($urandom_range(0, 15)));
      if ($urandom_range(0, 3) == 0) send_noise();
      if ($urandom_range(0, 7) == 0) send_item(REQ_ECHO, 1'b0, 4'($urandom_range(0, 15)));
      send_item(REQ_ECHO, 1'b1, 4'($urandom_range(0, 15)));
      pick = $urandom_range(0, 9);
      if (pick < 9) ticks = $urandom_range(0, 12);
      else ticks = $urandom_range(CM_DIVISOR, 2 * CM_DIVISOR + 14);
      for (int i = 0; i < ticks; i++) begin
         if ($urandom_range(0, 49) == 0) send_noise();
         send_item(REQ_TICK, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
      end
      if ($urandom_range(0, 9) != 0) send_item(REQ_ECHO, 1'b0, 4'($urandom_range(0, 15)));
      if ($urandom_range(0, 2) == 0) send_item(REQ_MOTOR, 1'($urandom_range(0, 1)),
                                               4'($urandom_range(0, 15)));
   endtask

   task automatic test_random_sequences();
      int goal;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 0) configure(0, 0, 1, 1);
         else if (p == 1) configure(1129, 126, 31, 31);
         else configure(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1129)
                                                    : $urandom_range(0, 3),
                        ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                    : $urandom_range(0, 6),
                        $urandom_range(0, 31), $urandom_range(0, 31));
         goal = sent_items + RANDOM_ITEMS / RANDOM_PHASES;
         while (sent_items < goal) run_measurement_sequence();
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_status_requests();
      test_measurement_cycle();
      test_register_extremes();
      test_busy_read_limit();
      test_distance_guard();
      test_backpressure();
      test_random_sequences();
      wait_idle();
      repeat (8) @(posedge clock);
      if (errors == 0 && awaited_status.size() == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule

### filelist.f
hdl/urmg_pkg.sv
hdl/urmg_csr.sv
hdl/urmg_div58.sv
hdl/urmg_core.sv
hdl/ultrasonic_ranger_motor_guard.sv
test/ultrasonic_ranger_motor_guard_tb.sv
